/* hw/rtl/rat_pkg.sv */
// ---------------------------------------------------------------------------
// rat_pkg: shared types and constants of the region address translator
// Action, status, access and permission codes, the region entry layout and
// the table write command.
// ---------------------------------------------------------------------------
package rat_pkg;

  localparam int DEFAULT_REGION_ENTRIES = 16;

  localparam int ADDR_W = 64;
  localparam int PERM_W = 3;

  // Request actions (travel on in_tuser)
  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_MAP       = 2'd1;
  localparam logic [1:0] ACT_UNMAP     = 2'd2;
  localparam logic [1:0] ACT_CLEAR     = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_PROT = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Access kinds
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_EXEC  = 2'd2;

  // Permission bits
  localparam logic [PERM_W-1:0] PERM_READ  = 3'h1;
  localparam logic [PERM_W-1:0] PERM_WRITE = 3'h2;
  localparam logic [PERM_W-1:0] PERM_EXEC  = 3'h4;
  localparam logic [PERM_W-1:0] PERM_NONE  = 3'h0;

  typedef struct packed {
    logic [ADDR_W-1:0] vbase;
    logic [ADDR_W-1:0] pbase;
    logic [ADDR_W-1:0] length;
    logic [PERM_W-1:0] perm;
  } rat_entry_t;

  // Table update command from the sequencer
  typedef struct packed {
    logic write;      // write entry at wr_addr and mark it valid
    logic inval;      // drop entry at wr_addr
    logic clear_all;  // drop every entry
  } rat_tbl_cmd_t;

  // Permission bit that an access kind needs; the unused code needs none
  function automatic logic [PERM_W-1:0] perm_for_access(input logic [1:0] acc);
    logic [PERM_W-1:0] bits;
    unique case (acc)
      ACC_READ:  bits = PERM_READ;
      ACC_WRITE: bits = PERM_WRITE;
      ACC_EXEC:  bits = PERM_EXEC;
      default:   bits = PERM_NONE;
    endcase
    return bits;
  endfunction

endpackage

/* hw/rtl/rat_table.sv */
// ---------------------------------------------------------------------------
// rat_table: region table storage
// Entry memory with one write port and one registered read port, plus a
// valid flag per entry in flops that reset clears.
// ---------------------------------------------------------------------------
module rat_table #(
  parameter int REGION_ENTRIES = rat_pkg::DEFAULT_REGION_ENTRIES,
  parameter int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     rd_addr,
  output rat_pkg::rat_entry_t  rd_entry,
  output logic                 rd_valid,
  input  rat_pkg::rat_tbl_cmd_t cmd,
  input  logic [IDX_W-1:0]     wr_addr,
  input  rat_pkg::rat_entry_t  wr_entry
);
  import rat_pkg::*;

  rat_entry_t                mem [REGION_ENTRIES];
  logic [REGION_ENTRIES-1:0] valid_r;
  rat_entry_t                rd_entry_r;
  logic                      rd_valid_r;

  // Entry memory: write port and registered read
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (cmd.clear_all) begin
        valid_r <= '0;
      end else if (cmd.write) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (cmd.inval) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

/* hw/rtl/rat_engine.sv */
// ---------------------------------------------------------------------------
// rat_engine: request sequencer
// Scans the region table one entry per cycle through a single compare unit,
// then updates the table or finishes the translation (offset, bound and
// permission check, physical add). Clears and MMU-off translates skip the scan.
// ---------------------------------------------------------------------------
module rat_engine #(
  parameter int REGION_ENTRIES = rat_pkg::DEFAULT_REGION_ENTRIES,
  parameter int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mmu_enable,
  // request
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    req_action,
  input  logic [rat_pkg::ADDR_W-1:0]    req_vaddr,
  input  logic [rat_pkg::ADDR_W-1:0]    req_pbase,
  input  logic [rat_pkg::ADDR_W-1:0]    req_size,
  input  logic [rat_pkg::PERM_W-1:0]    req_perm,
  input  logic [1:0]                    req_access,
  // result
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    res_status,
  output logic [rat_pkg::ADDR_W-1:0]    res_paddr,
  // table
  output logic [IDX_W-1:0]              tbl_rd_addr,
  input  rat_pkg::rat_entry_t           tbl_rd_entry,
  input  logic                          tbl_rd_valid,
  output rat_pkg::rat_tbl_cmd_t         tbl_cmd,
  output logic [IDX_W-1:0]              tbl_wr_addr,
  output rat_pkg::rat_entry_t           tbl_wr_entry
);
  import rat_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_ENTRIES - 1);

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             eval_vld_r, eval_vld_nxt;
  logic             best_found_r, best_found_nxt;
  logic             match_found_r, match_found_nxt;
  logic             free_found_r, free_found_nxt;

  // payload
  logic [1:0]        act_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] pbase_r;
  logic [ADDR_W-1:0] len_r;
  logic [PERM_W-1:0] perm_r;
  logic [1:0]        acc_r;
  logic [IDX_W-1:0]  eval_idx_r;
  rat_entry_t        best_r, best_nxt;
  logic [IDX_W-1:0]  match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [ADDR_W-1:0] offs_r, offs_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] paddr_r, paddr_nxt;

  logic accept;
  logic cand_hit, match_hit, free_hit;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_status = status_r;
  assign res_paddr  = paddr_r;

  assign tbl_rd_addr  = cnt_r;
  assign tbl_wr_entry = '{vbase: addr_r, pbase: pbase_r, length: len_r, perm: perm_r};

  // Shared compare unit on the entry read back this cycle
  assign cand_hit  = eval_vld_r && tbl_rd_valid && (tbl_rd_entry.vbase <= addr_r) &&
                     (!best_found_r || (tbl_rd_entry.vbase > best_r.vbase));
  assign match_hit = eval_vld_r && tbl_rd_valid && (tbl_rd_entry.vbase == addr_r) &&
                     !match_found_r;
  assign free_hit  = eval_vld_r && !tbl_rd_valid && !free_found_r;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    eval_vld_nxt    = 1'b0;
    best_found_nxt  = best_found_r || cand_hit;
    best_nxt        = cand_hit ? tbl_rd_entry : best_r;
    match_found_nxt = match_found_r || match_hit;
    match_idx_nxt   = match_hit ? eval_idx_r : match_idx_r;
    free_found_nxt  = free_found_r || free_hit;
    free_idx_nxt    = free_hit ? eval_idx_r : free_idx_r;
    offs_nxt        = offs_r;
    status_nxt      = status_r;
    paddr_nxt       = paddr_r;
    tbl_cmd         = '0;
    tbl_wr_addr     = match_found_r ? match_idx_r : free_idx_r;

    unique case (state_r)
      S_IDLE: begin
        best_found_nxt  = 1'b0;
        match_found_nxt = 1'b0;
        free_found_nxt  = 1'b0;
        cnt_nxt         = '0;
        if (accept) begin
          status_nxt = ST_OK;
          paddr_nxt  = '0;
          if (req_action == ACT_CLEAR) begin
            tbl_cmd.clear_all = 1'b1;
            state_nxt         = S_DONE;
          end else if (req_action == ACT_TRANSLATE && !mmu_enable) begin
            paddr_nxt = req_vaddr;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        eval_vld_nxt = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_POST;
      end
      S_POST: begin
        state_nxt = S_DONE;
        if (act_r == ACT_TRANSLATE) begin
          if (!best_found_r) begin
            status_nxt = ST_MISS;
          end else begin
            offs_nxt  = addr_r - best_r.vbase;
            state_nxt = S_CHECK;
          end
        end else if (act_r == ACT_MAP) begin
          if (match_found_r || free_found_r) begin
            tbl_cmd.write = 1'b1;
          end else begin
            status_nxt = ST_FULL;
          end
        end else begin
          tbl_cmd.inval = match_found_r;
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (offs_r >= best_r.length) begin
          status_nxt = ST_MISS;
        end else if ((best_r.perm & perm_for_access(acc_r)) == PERM_NONE) begin
          status_nxt = ST_PROT;
        end else begin
          paddr_nxt = best_r.pbase + offs_r;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      eval_vld_r    <= 1'b0;
      best_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      eval_vld_r    <= eval_vld_nxt;
      best_found_r  <= best_found_nxt;
      match_found_r <= match_found_nxt;
      free_found_r  <= free_found_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= req_action;
      addr_r  <= req_vaddr;
      pbase_r <= req_pbase;
      len_r   <= req_size;
      perm_r  <= req_perm;
      acc_r   <= req_access;
    end
    eval_idx_r  <= cnt_r;
    best_r      <= best_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    offs_r      <= offs_nxt;
    status_r    <= status_nxt;
    paddr_r     <= paddr_nxt;
  end

endmodule

/* hw/rtl/region_address_translator.sv */
// ---------------------------------------------------------------------------
// region_address_translator: region table with read/write/execute checks
// Maps, unmaps and clears regions and translates addresses against them.
// ---------------------------------------------------------------------------
// One item is worked at a time. A translate with mmu_enable high, a map or
// an unmap walks the whole region table through one comparator, one entry
// per cycle from the single table read port. After the walk, a translate
// that finds a region at or below its address goes on to a bound and
// permission check before its result reaches out_. A new item is taken the
// cycle after the result leaves the sequencer. A clear, or a translate with
// mmu_enable low, skips the walk and goes straight to its result.
// Results sit in an output register, so the next item can start while the
// previous result waits. cfg_wr_en may be raised only while no item is in
// flight.
module region_address_translator #(
  parameter int REGION_ENTRIES = rat_pkg::DEFAULT_REGION_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,    // mmu_enable
  // request items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,       // virtual_address, physical_base, region_size,
                                       // permission_flags, access_type, zero pad
  input  logic [1:0]   in_tuser,       // action
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata       // status, physical_address, zero pad
);
  import rat_pkg::*;

  localparam int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;

  logic              mmu_en_r;
  logic              res_valid, res_ready;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_paddr;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_paddr_r;

  logic [IDX_W-1:0]  tbl_rd_addr, tbl_wr_addr;
  rat_entry_t        tbl_rd_entry, tbl_wr_entry;
  logic              tbl_rd_valid;
  rat_tbl_cmd_t      tbl_cmd;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmu_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mmu_en_r <= cfg_wr_data;
    end
  end

  rat_table #(
    .REGION_ENTRIES(REGION_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (tbl_rd_addr),
    .rd_entry(tbl_rd_entry),
    .rd_valid(tbl_rd_valid),
    .cmd     (tbl_cmd),
    .wr_addr (tbl_wr_addr),
    .wr_entry(tbl_wr_entry)
  );

  rat_engine #(
    .REGION_ENTRIES(REGION_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .mmu_enable  (mmu_en_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_action  (in_tuser),
    .req_vaddr   (in_tdata[63:0]),
    .req_pbase   (in_tdata[127:64]),
    .req_size    (in_tdata[191:128]),
    .req_perm    (in_tdata[194:192]),
    .req_access  (in_tdata[196:195]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_status  (res_status),
    .res_paddr   (res_paddr),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_entry(tbl_rd_entry),
    .tbl_rd_valid(tbl_rd_valid),
    .tbl_cmd     (tbl_cmd),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_entry(tbl_wr_entry)
  );

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_status_r <= res_status;
      out_paddr_r  <= res_paddr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_paddr_r, out_status_r};

endmodule
